[rtl/lfe_pkg.sv]
// lazy flag evaluator package: operation kinds, condition selects, flag bit places
// width helpers shared by the carry, arithmetic and flag core units
// no dependencies
`default_nettype none

package lfe_pkg;

	// lazy operation kinds, byte/word/dword per group
	localparam logic [4:0] K_ADD_B   = 5'd0;
	localparam logic [4:0] K_ADD_W   = 5'd1;
	localparam logic [4:0] K_ADD_D   = 5'd2;
	localparam logic [4:0] K_ADC_B   = 5'd3;
	localparam logic [4:0] K_ADC_W   = 5'd4;
	localparam logic [4:0] K_ADC_D   = 5'd5;
	localparam logic [4:0] K_SUB_B   = 5'd6;
	localparam logic [4:0] K_SUB_W   = 5'd7;
	localparam logic [4:0] K_SUB_D   = 5'd8;
	localparam logic [4:0] K_SBB_B   = 5'd9;
	localparam logic [4:0] K_SBB_W   = 5'd10;
	localparam logic [4:0] K_SBB_D   = 5'd11;
	localparam logic [4:0] K_LOGIC_B = 5'd12;
	localparam logic [4:0] K_LOGIC_W = 5'd13;
	localparam logic [4:0] K_LOGIC_D = 5'd14;
	localparam logic [4:0] K_SHL_B   = 5'd15;
	localparam logic [4:0] K_SHL_W   = 5'd16;
	localparam logic [4:0] K_SHL_D   = 5'd17;
	localparam logic [4:0] K_SHR_B   = 5'd18;
	localparam logic [4:0] K_SHR_W   = 5'd19;
	localparam logic [4:0] K_SHR_D   = 5'd20;
	localparam logic [4:0] K_MUL_B   = 5'd21;
	localparam logic [4:0] K_MUL_W   = 5'd22;
	localparam logic [4:0] K_MUL_D   = 5'd23;
	localparam logic [4:0] K_DIRECT  = 5'd24;
	localparam logic [4:0] K_INC_B   = 5'd25;
	localparam logic [4:0] K_INC_W   = 5'd26;
	localparam logic [4:0] K_INC_D   = 5'd27;
	localparam logic [4:0] K_DEC_B   = 5'd28;
	localparam logic [4:0] K_DEC_W   = 5'd29;
	localparam logic [4:0] K_DEC_D   = 5'd30;
	// the one code past the table, folds onto byte add for AF/OF
	localparam logic [4:0] K_ALIAS   = 5'd31;
	// carry kinds wrap at this count
	localparam logic [4:0] CF_WRAP   = 5'd25;

	// overflow patterns of inc/dec results
	localparam logic [7:0]  INC_OVF_B = 8'h80;
	localparam logic [15:0] INC_OVF_W = 16'h8000;
	localparam logic [31:0] INC_OVF_D = 32'h8000_0000;
	localparam logic [7:0]  DEC_OVF_B = 8'h7f;
	localparam logic [15:0] DEC_OVF_W = 16'h7fff;
	localparam logic [31:0] DEC_OVF_D = 32'h7fff_ffff;

	// condition selects, cond_code bits 3..1
	localparam logic [2:0] COND_O  = 3'd0;
	localparam logic [2:0] COND_B  = 3'd1;
	localparam logic [2:0] COND_Z  = 3'd2;
	localparam logic [2:0] COND_BE = 3'd3;
	localparam logic [2:0] COND_S  = 3'd4;
	localparam logic [2:0] COND_P  = 3'd5;
	localparam logic [2:0] COND_L  = 3'd6;
	localparam logic [2:0] COND_LE = 3'd7;

	// flag word bit places
	localparam int FLAG_CF = 0;
	localparam int FLAG_PF = 2;
	localparam int FLAG_AF = 4;
	localparam int FLAG_ZF = 6;
	localparam int FLAG_SF = 7;
	localparam int FLAG_OF = 11;
	localparam int FLAG_W  = 12;

	typedef enum logic [1:0] {
		W_BYTE,
		W_WORD,
		W_DWORD
	} width_t;

	// carry unit result
	typedef struct packed {
		logic cf;
		logic ult;
		logic eq;
	} carry_t;

	// arithmetic unit result
	typedef struct packed {
		logic        af;
		logic        of;
		logic [31:0] sum;
	} arith_t;

	// operand width of a kind (kind mod 3)
	function automatic width_t kind_width(input logic [4:0] k);
		width_t w;
		case (k) inside
			K_ADD_B, K_ADC_B, K_SUB_B, K_SBB_B, K_LOGIC_B, K_SHL_B, K_SHR_B, K_MUL_B,
			K_DIRECT, K_INC_D, K_DEC_D: w = W_BYTE;
			K_ADD_W, K_ADC_W, K_SUB_W, K_SBB_W, K_LOGIC_W, K_SHL_W, K_SHR_W, K_MUL_W,
			K_INC_B, K_DEC_B, K_ALIAS: w = W_WORD;
			default: w = W_DWORD;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] width_mask(input width_t w);
		logic [31:0] m;
		case (w)
			W_BYTE:  m = 32'h0000_00ff;
			W_WORD:  m = 32'h0000_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	// sign bit of a value at the given width
	function automatic logic sign_at(input logic [31:0] v, input width_t w);
		logic b;
		case (w)
			W_BYTE:  b = v[7];
			W_WORD:  b = v[15];
			default: b = v[31];
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

[rtl/x86_lazy_flag_evaluator.sv]
// a taken word passes the input register, the flag logic and the output register
// on its way to the output (two register stages)
// throughput: one word per cycle while the output drains; behind a stalled word one more fits
// in_stall rises only when both stages hold a word and the output is stalled
// reset (arst_n low, asynchronous) empties both stages; the output shows no word
`default_nettype none

module x86_lazy_flag_evaluator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [4:0]         op_kind,
	input  logic signed [31:0] operand_src,
	input  logic signed [31:0] result_dst,
	input  logic [4:0]         saved_kind,
	input  logic [31:0]        saved_result,
	input  logic [3:0]         cond_code,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               cond_taken,
	output logic [11:0]        flag_word
);

	logic                        valid_s1;
	logic                        func_s1;
	logic [4:0]                  op_kind_s1;
	logic [31:0]                 src_s1;
	logic [31:0]                 dst_s1;
	logic [4:0]                  saved_kind_s1;
	logic [31:0]                 saved_result_s1;
	logic [3:0]                  cond_code_s1;
	logic                        valid_s2;
	logic                        cond_taken_s2;
	logic [lfe_pkg::FLAG_W-1:0]  flag_word_s2;
	logic                        adv_s2;
	logic                        take;
	logic                        cond_taken_c;
	logic [lfe_pkg::FLAG_W-1:0]  flag_word_c;

	// stage 2 loads when empty or being drained; stage 1 moves with it
	assign adv_s2   = ~valid_s2 | ~out_stall;
	assign in_stall = valid_s1 & ~adv_s2;
	assign take     = in_valid & ~in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (~valid_s1 | adv_s2) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1         <= func;
			op_kind_s1      <= op_kind;
			src_s1          <= $unsigned(operand_src);
			dst_s1          <= $unsigned(result_dst);
			saved_kind_s1   <= saved_kind;
			saved_result_s1 <= saved_result;
			cond_code_s1    <= cond_code;
		end
	end

	// flag evaluation
	lfe_flag_core u_core (
		.func         (func_s1),
		.op_kind      (op_kind_s1),
		.src          (src_s1),
		.dst          (dst_s1),
		.saved_kind   (saved_kind_s1),
		.saved_result (saved_result_s1),
		.cond_code    (cond_code_s1),
		.cond_taken   (cond_taken_c),
		.flag_word    (flag_word_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			cond_taken_s2 <= cond_taken_c;
			flag_word_s2  <= flag_word_c;
		end
	end

	assign out_valid  = valid_s2;
	assign cond_taken = cond_taken_s2;
	assign flag_word  = flag_word_s2;

endmodule

`default_nettype wire

[rtl/lfe_carry_unit.sv]
// carry unit: CF from the record, plus the masked unsigned compare it is built on
// depends on lfe_pkg
`default_nettype none

module lfe_carry_unit (
	input  logic [4:0]       op_kind,
	input  logic [31:0]      src,
	input  logic [31:0]      dst,
	input  logic [4:0]       saved_kind,
	input  logic [31:0]      saved_result,
	output lfe_pkg::carry_t  carry
);

	logic [4:0]           k_raw;
	logic [4:0]           k;
	logic [31:0]          cd;
	lfe_pkg::width_t      w;
	logic [31:0]          m;
	logic                 cin;
	logic [31:0]          sum;
	logic [31:0]          x;
	logic [31:0]          xm;
	logic [31:0]          sm;
	logic                 ult;
	logic                 eq;

	// inc/dec keep the carry of the earlier record
	assign k_raw = (op_kind >= lfe_pkg::K_INC_B) ? saved_kind : op_kind;
	assign cd    = (op_kind >= lfe_pkg::K_INC_B) ? saved_result : dst;
	assign k     = (k_raw >= lfe_pkg::CF_WRAP) ? (k_raw - lfe_pkg::CF_WRAP) : k_raw;
	assign w     = lfe_pkg::kind_width(k);
	assign m     = lfe_pkg::width_mask(w);

	// rebuild the first operand of sub/sbb, then compare against the source
	assign cin = (k >= lfe_pkg::K_SBB_B) && (k <= lfe_pkg::K_SBB_D);
	assign sum = cd + src + {31'b0, cin};
	assign x   = (k <= lfe_pkg::K_ADC_D) ? cd : sum;
	assign xm  = x & m;
	assign sm  = src & m;
	assign ult = xm < sm;
	assign eq  = xm == sm;

	// carry per kind group
	always_comb begin
		carry.ult = ult;
		carry.eq  = eq;
		case (k) inside
			[lfe_pkg::K_ADD_B:lfe_pkg::K_ADD_D],
			[lfe_pkg::K_SUB_B:lfe_pkg::K_SUB_D]:   carry.cf = ult;
			[lfe_pkg::K_ADC_B:lfe_pkg::K_ADC_D],
			[lfe_pkg::K_SBB_B:lfe_pkg::K_SBB_D]:   carry.cf = ult | eq;
			[lfe_pkg::K_LOGIC_B:lfe_pkg::K_LOGIC_D]: carry.cf = 1'b0;
			[lfe_pkg::K_SHL_B:lfe_pkg::K_SHL_D]:   carry.cf = lfe_pkg::sign_at(src, w);
			[lfe_pkg::K_SHR_B:lfe_pkg::K_SHR_D]:   carry.cf = src[0];
			[lfe_pkg::K_MUL_B:lfe_pkg::K_MUL_D]:   carry.cf = |src;
			default:                               carry.cf = src[0];
		endcase
	end

endmodule

`default_nettype wire

[rtl/lfe_arith_unit.sv]
// arithmetic unit: rebuilt operand, AF and OF of the recorded operation
// depends on lfe_pkg
`default_nettype none

module lfe_arith_unit (
	input  logic [4:0]       op_kind,
	input  logic [31:0]      src,
	input  logic [31:0]      dst,
	output lfe_pkg::arith_t  arith
);

	logic [4:0]       k;
	lfe_pkg::width_t  w;
	logic             sub;
	logic             cin;
	logic [31:0]      b;
	logic [31:0]      a;
	logic             ovf_add;
	logic             ovf_sub;

	// code 31 folds onto byte add
	assign k = (op_kind == lfe_pkg::K_ALIAS) ? lfe_pkg::K_ADD_B : op_kind;
	assign w = lfe_pkg::kind_width(k);

	// a = d - s (-1) for add/adc, d + s (+1) for sub/sbb
	assign sub = k <= lfe_pkg::K_ADC_D;
	assign cin = (k <= lfe_pkg::K_ADD_D) || ((k >= lfe_pkg::K_SBB_B) && (k <= lfe_pkg::K_SBB_D));
	assign b   = sub ? ~src : src;
	assign a   = dst + b + {31'b0, cin};

	assign ovf_sub = lfe_pkg::sign_at(~(a ^ src) & (a ^ dst), w);
	assign ovf_add = lfe_pkg::sign_at((a ^ src) & (a ^ dst), w);

	// overflow per kind
	always_comb begin
		arith.sum = a;
		case (k) inside
			[lfe_pkg::K_ADD_B:lfe_pkg::K_ADC_D]:     arith.of = ovf_sub;
			[lfe_pkg::K_SUB_B:lfe_pkg::K_SBB_D]:     arith.of = ovf_add;
			[lfe_pkg::K_LOGIC_B:lfe_pkg::K_LOGIC_D]: arith.of = 1'b0;
			[lfe_pkg::K_SHL_B:lfe_pkg::K_SHR_D]:     arith.of = lfe_pkg::sign_at(src ^ dst, w);
			[lfe_pkg::K_MUL_B:lfe_pkg::K_MUL_D]:     arith.of = |src;
			lfe_pkg::K_DIRECT: arith.of = src[lfe_pkg::FLAG_OF];
			lfe_pkg::K_INC_B:  arith.of = dst[7:0] == lfe_pkg::INC_OVF_B;
			lfe_pkg::K_INC_W:  arith.of = dst[15:0] == lfe_pkg::INC_OVF_W;
			lfe_pkg::K_INC_D:  arith.of = dst == lfe_pkg::INC_OVF_D;
			lfe_pkg::K_DEC_B:  arith.of = dst[7:0] == lfe_pkg::DEC_OVF_B;
			lfe_pkg::K_DEC_W:  arith.of = dst[15:0] == lfe_pkg::DEC_OVF_W;
			default:           arith.of = dst == lfe_pkg::DEC_OVF_D;
		endcase
	end

	// aux carry out of bit 3; inc/dec only look at the low nibble
	always_comb begin
		case (k) inside
			[lfe_pkg::K_ADD_B:lfe_pkg::K_SBB_D]:   arith.af = dst[4] ^ a[4] ^ src[4];
			[lfe_pkg::K_LOGIC_B:lfe_pkg::K_MUL_D]: arith.af = 1'b0;
			lfe_pkg::K_DIRECT:                     arith.af = src[lfe_pkg::FLAG_AF];
			[lfe_pkg::K_INC_B:lfe_pkg::K_INC_D]:   arith.af = dst[3:0] == 4'h0;
			default:                               arith.af = dst[3:0] == 4'hf;
		endcase
	end

endmodule

`default_nettype wire

[rtl/lfe_flag_core.sv]
// flag core: combines carry and arithmetic units into the flag word and condition
// depends on lfe_pkg, lfe_carry_unit, lfe_arith_unit
`default_nettype none

module lfe_flag_core (
	input  logic                        func,
	input  logic [4:0]                  op_kind,
	input  logic [31:0]                 src,
	input  logic [31:0]                 dst,
	input  logic [4:0]                  saved_kind,
	input  logic [31:0]                 saved_result,
	input  logic [3:0]                  cond_code,
	output logic                        cond_taken,
	output logic [lfe_pkg::FLAG_W-1:0]  flag_word
);

	lfe_pkg::carry_t  carry;
	lfe_pkg::arith_t  arith;
	lfe_pkg::width_t  wo;
	logic             direct;
	logic             zf;
	logic             sf;
	logic             pf;
	logic             oe;
	logic             slt;
	logic             less;
	logic             below_eq;
	logic             r;

	lfe_carry_unit u_carry (
		.op_kind      (op_kind),
		.src          (src),
		.dst          (dst),
		.saved_kind   (saved_kind),
		.saved_result (saved_result),
		.carry        (carry)
	);

	lfe_arith_unit u_arith (
		.op_kind (op_kind),
		.src     (src),
		.dst     (dst),
		.arith   (arith)
	);

	// simple flags
	assign direct = op_kind == lfe_pkg::K_DIRECT;
	assign zf     = dst == 32'h0;
	assign sf     = direct ? src[lfe_pkg::FLAG_SF] : dst[31];
	assign pf     = direct ? src[lfe_pkg::FLAG_PF] : ~(^dst[7:0]);

	// signed compare for sub kinds, rebuilt operand against source
	assign wo  = lfe_pkg::kind_width(op_kind);
	assign slt = (lfe_pkg::sign_at(arith.sum, wo) != lfe_pkg::sign_at(src, wo))
		? lfe_pkg::sign_at(arith.sum, wo) : carry.ult;
	assign oe  = cond_code[1];

	// less / less-or-equal
	always_comb begin
		case (op_kind) inside
			[lfe_pkg::K_SUB_B:lfe_pkg::K_SUB_D]: less = slt | (oe & carry.eq);
			[lfe_pkg::K_LOGIC_B:lfe_pkg::K_LOGIC_D],
			[lfe_pkg::K_INC_B:lfe_pkg::K_DEC_D]: less = dst[31] | (oe & zf);
			lfe_pkg::K_DIRECT: less = (src[lfe_pkg::FLAG_SF] ^ src[lfe_pkg::FLAG_OF])
				| (oe & src[lfe_pkg::FLAG_ZF]);
			default: less = (dst[31] ^ arith.of) | (oe & zf);
		endcase
	end

	// below-or-equal
	always_comb begin
		case (op_kind) inside
			[lfe_pkg::K_SUB_B:lfe_pkg::K_SUB_D]: below_eq = carry.ult | carry.eq;
			lfe_pkg::K_DIRECT: below_eq = src[lfe_pkg::FLAG_ZF] | src[lfe_pkg::FLAG_CF];
			default:           below_eq = carry.cf | zf;
		endcase
	end

	// condition select
	always_comb begin
		unique case (cond_code[3:1])
			lfe_pkg::COND_O:  r = arith.of;
			lfe_pkg::COND_B:  r = carry.cf;
			lfe_pkg::COND_Z:  r = zf;
			lfe_pkg::COND_BE: r = below_eq;
			lfe_pkg::COND_S:  r = sf;
			lfe_pkg::COND_P:  r = pf;
			lfe_pkg::COND_L:  r = less;
			lfe_pkg::COND_LE: r = less;
			default:          r = 1'b0;
		endcase
	end
	assign cond_taken = r ^ cond_code[0];

	// flag word, shift form drops CF and OF
	always_comb begin
		flag_word                   = '0;
		flag_word[lfe_pkg::FLAG_CF] = ~func & carry.cf;
		flag_word[lfe_pkg::FLAG_PF] = pf;
		flag_word[lfe_pkg::FLAG_AF] = arith.af;
		flag_word[lfe_pkg::FLAG_ZF] = zf;
		flag_word[lfe_pkg::FLAG_SF] = sf;
		flag_word[lfe_pkg::FLAG_OF] = ~func & arith.of;
	end

endmodule

`default_nettype wire

[rtl/lfe_checker.sv]
// port checker for the lazy flag evaluator, bound to the top level
// depends on x86_lazy_flag_evaluator port names only
`default_nettype none

module lfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        cond_taken,
	input logic [11:0] flag_word
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(flag_word) && $stable(cond_taken))
		else $error("output word changed while stalled");

	// input backs up only behind a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with room in the output stage");

	// a taken word is followed by a valid word on the output
	a_reach_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##2 out_valid)
		else $error("taken word did not reach the output");

	// unused flag word bits stay clear
	a_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !flag_word[1] && !flag_word[3] && !flag_word[5]
			&& !flag_word[8] && !flag_word[9] && !flag_word[10])
		else $error("reserved flag word bit set");

endmodule

bind x86_lazy_flag_evaluator lfe_checker u_lfe_checker (.*);

`default_nettype wire
